### rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the password capability checker
// Item layouts, command and status bundles, codes and the rights masks.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    // Rights handling; the rights fields are fixed at 16 bits.
    localparam int RIGHTS_BITS = 16;
    localparam int DENY_BIT    = 15;
    localparam int CALL_BIT    = 14;

    localparam logic [15:0] RIGHTS_MASK =
        (RIGHTS_BITS >= 16) ? 16'hFFFF : ((16'd1 << RIGHTS_BITS) - 16'd1);
    localparam logic [15:0] DENY_MASK = (DENY_BIT < 16) ? (16'd1 << DENY_BIT) : 16'd0;
    localparam logic [15:0] CALL_MASK = (CALL_BIT < 16) ? (16'd1 << CALL_BIT) : 16'd0;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD_CAP   = 2'd0;
    localparam logic [1:0] KIND_LOAD_SLOT  = 2'd1;
    localparam logic [1:0] KIND_LOAD_ENTRY = 2'd2;
    localparam logic [1:0] KIND_VALIDATE   = 2'd3;

    // Verdict codes.
    localparam logic [1:0] VERDICT_ALLOWED = 2'd0;
    localparam logic [1:0] VERDICT_DENIED  = 2'd1;
    localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CAP_COUNT = 1'b0;
    localparam logic CFG_PDX_COUNT = 1'b1;

    localparam int CFG_DATA_W = 5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic [63:0] password;
        logic [15:0] rights_mask;
        logic [5:0]  first_entry;
        logic [5:0]  end_entry;
        logic [63:0] address;
        logic [15:0] requested_access;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] granted_mask;
        logic [2:0]  call_slot;
        logic        call_slot_valid;
    } t_out_item;

    // Stored table records.
    typedef struct packed {
        logic [63:0] password;
        logic [15:0] rights;
    } t_cap_rec;

    typedef struct packed {
        logic [63:0] password;
        logic [5:0]  first_entry;
        logic [5:0]  end_entry;
    } t_slot_rec;

    typedef enum logic [1:0] {
        RES_UNKNOWN,
        RES_DENIED,
        RES_CAP_OK,
        RES_CALL_OK
    } t_res_sel;

    typedef struct packed {
        logic     accept;    // input beat taken this cycle
        logic     item_load; // capture a validate item
        logic     cap_clr;
        logic     cap_inc;
        logic     slot_clr;
        logic     slot_inc;
        logic     ep_start;
        logic     ep_inc;
        logic     res_load;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic in_call;
        logic cap_end;
        logic cap_match;
        logic cap_deny;
        logic cap_allow;
        logic slot_end;
        logic slot_match;
        logic ep_end;
        logic ep_match;
    } t_status;

endpackage

`default_nettype wire

### rtl/pcc_ram.sv
// ----------------------------------------------------------------------------
// pcc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/pcc_datapath.sv
// ----------------------------------------------------------------------------
// pcc_datapath: tables, scan counters and result register
// Holds the three tables, the count registers, the captured validate item,
// the scan indexes and the output register; reports compare results.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_datapath #(
    parameter int CAP_SLOTS    = 16,
    parameter int CALL_SLOTS   = 8,
    parameter int ENTRY_POINTS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [pcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire pcc_pkg::t_in_item             i_in_item,
    input  wire pcc_pkg::t_cmd                 i_cmd,
    output pcc_pkg::t_status                   o_status,
    output pcc_pkg::t_out_item                 o_out_item
);

    localparam int CAP_AW  = (CAP_SLOTS > 1) ? $clog2(CAP_SLOTS) : 1;
    localparam int CALL_AW = (CALL_SLOTS > 1) ? $clog2(CALL_SLOTS) : 1;
    localparam int EP_AW   = (ENTRY_POINTS > 1) ? $clog2(ENTRY_POINTS) : 1;
    localparam int CAP_CW  = ($clog2(CAP_SLOTS + 1) > 5) ? $clog2(CAP_SLOTS + 1) : 5;
    localparam int CALL_CW = ($clog2(CALL_SLOTS + 1) > 4) ? $clog2(CALL_SLOTS + 1) : 4;
    localparam int EP_CW   = ($clog2(ENTRY_POINTS + 1) > 6) ? $clog2(ENTRY_POINTS + 1) : 6;

    logic [4:0]         r_cap_count;
    logic [3:0]         r_pdx_count;
    logic [63:0]        r_pw;
    logic [15:0]        r_acc;
    logic [63:0]        r_addr;
    logic [CAP_CW-1:0]  r_ci;
    logic [CALL_CW-1:0] r_si;
    logic [EP_CW-1:0]   r_ej;
    logic [EP_CW-1:0]   r_ee;
    pcc_pkg::t_out_item r_out;
    pcc_pkg::t_out_item n_out;

    pcc_pkg::t_cap_rec  cap_wrec;
    pcc_pkg::t_cap_rec  cap_rrec;
    pcc_pkg::t_slot_rec slot_wrec;
    pcc_pkg::t_slot_rec slot_rrec;
    logic [63:0]        ep_rdata;
    logic               cap_we;
    logic               slot_we;
    logic               ep_we;
    logic [15:0]        in_acc;
    logic [15:0]        cap_rights;
    logic [CAP_CW-1:0]  cap_cnt_w;
    logic [CAP_CW-1:0]  cap_lim;
    logic [CALL_CW-1:0] pdx_cnt_w;
    logic [CALL_CW-1:0] pdx_lim;
    logic [EP_CW-1:0]   end_w;
    logic [EP_CW-1:0]   end_lim;

    // Loads go straight from the input beat into the tables.
    assign cap_we  = i_cmd.accept && (i_in_item.kind == pcc_pkg::KIND_LOAD_CAP)
                     && (32'(i_in_item.slot) < 32'(CAP_SLOTS));
    assign slot_we = i_cmd.accept && (i_in_item.kind == pcc_pkg::KIND_LOAD_SLOT)
                     && (32'(i_in_item.slot) < 32'(CALL_SLOTS));
    assign ep_we   = i_cmd.accept && (i_in_item.kind == pcc_pkg::KIND_LOAD_ENTRY)
                     && (32'(i_in_item.slot) < 32'(ENTRY_POINTS));

    assign cap_wrec.password     = i_in_item.password;
    assign cap_wrec.rights       = i_in_item.rights_mask;
    assign slot_wrec.password    = i_in_item.password;
    assign slot_wrec.first_entry = i_in_item.first_entry;
    assign slot_wrec.end_entry   = i_in_item.end_entry;

    pcc_ram #(.WIDTH($bits(pcc_pkg::t_cap_rec)), .DEPTH(CAP_SLOTS), .AW(CAP_AW)) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (cap_we),
        .i_waddr (CAP_AW'(i_in_item.slot)),
        .i_wdata (cap_wrec),
        .i_raddr (r_ci[CAP_AW-1:0]),
        .o_rdata (cap_rrec)
    );

    pcc_ram #(.WIDTH($bits(pcc_pkg::t_slot_rec)), .DEPTH(CALL_SLOTS), .AW(CALL_AW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (CALL_AW'(i_in_item.slot)),
        .i_wdata (slot_wrec),
        .i_raddr (r_si[CALL_AW-1:0]),
        .o_rdata (slot_rrec)
    );

    pcc_ram #(.WIDTH(64), .DEPTH(ENTRY_POINTS), .AW(EP_AW)) u_ep_ram (
        .i_clk   (i_clk),
        .i_we    (ep_we),
        .i_waddr (EP_AW'(i_in_item.slot)),
        .i_wdata (i_in_item.address),
        .i_raddr (r_ej[EP_AW-1:0]),
        .o_rdata (ep_rdata)
    );

    assign in_acc     = i_in_item.requested_access & pcc_pkg::RIGHTS_MASK;
    assign cap_rights = cap_rrec.rights & pcc_pkg::RIGHTS_MASK;

    // Table limits saturate at the table sizes.
    assign cap_cnt_w = CAP_CW'(r_cap_count);
    assign cap_lim   = (cap_cnt_w > CAP_CW'(CAP_SLOTS)) ? CAP_CW'(CAP_SLOTS) : cap_cnt_w;
    assign pdx_cnt_w = CALL_CW'(r_pdx_count);
    assign pdx_lim   = (pdx_cnt_w > CALL_CW'(CALL_SLOTS)) ? CALL_CW'(CALL_SLOTS) : pdx_cnt_w;
    assign end_w     = EP_CW'(slot_rrec.end_entry);
    assign end_lim   = (end_w > EP_CW'(ENTRY_POINTS)) ? EP_CW'(ENTRY_POINTS) : end_w;

    always_comb begin
        o_status.in_call    = (in_acc & pcc_pkg::CALL_MASK) != 16'd0;
        o_status.cap_end    = r_ci >= cap_lim;
        o_status.cap_match  = cap_rrec.password == r_pw;
        o_status.cap_deny   = ((r_acc & cap_rights) != 16'd0)
                              && ((cap_rights & pcc_pkg::DENY_MASK) != 16'd0);
        o_status.cap_allow  = (r_acc & ~cap_rights) == 16'd0;
        o_status.slot_end   = r_si >= pdx_lim;
        o_status.slot_match = slot_rrec.password == r_pw;
        o_status.ep_end     = r_ej >= r_ee;
        o_status.ep_match   = ep_rdata == r_addr;
    end

    always_comb begin
        n_out.verdict         = pcc_pkg::VERDICT_UNKNOWN;
        n_out.granted_mask    = r_acc;
        n_out.call_slot       = 3'd0;
        n_out.call_slot_valid = 1'b0;
        case (i_cmd.res_sel)
            pcc_pkg::RES_DENIED: begin
                n_out.verdict = pcc_pkg::VERDICT_DENIED;
            end
            pcc_pkg::RES_CAP_OK: begin
                n_out.verdict      = pcc_pkg::VERDICT_ALLOWED;
                n_out.granted_mask = cap_rights;
            end
            pcc_pkg::RES_CALL_OK: begin
                n_out.verdict         = pcc_pkg::VERDICT_ALLOWED;
                n_out.call_slot       = 3'(r_si);
                n_out.call_slot_valid = 1'b1;
            end
            default: begin
                n_out.verdict = pcc_pkg::VERDICT_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_count <= '0;
            r_pdx_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcc_pkg::CFG_CAP_COUNT: r_cap_count <= i_cfg_data;
                pcc_pkg::CFG_PDX_COUNT: r_pdx_count <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_pw   <= i_in_item.password;
            r_acc  <= in_acc;
            r_addr <= i_in_item.address;
        end
        if (i_cmd.cap_clr) begin
            r_ci <= '0;
        end else if (i_cmd.cap_inc) begin
            r_ci <= r_ci + CAP_CW'(1);
        end
        if (i_cmd.slot_clr) begin
            r_si <= '0;
        end else if (i_cmd.slot_inc) begin
            r_si <= r_si + CALL_CW'(1);
        end
        if (i_cmd.ep_start) begin
            r_ej <= EP_CW'(slot_rrec.first_entry);
            r_ee <= end_lim;
        end else if (i_cmd.ep_inc) begin
            r_ej <= r_ej + EP_CW'(1);
        end
        if (i_cmd.res_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

`default_nettype wire

### rtl/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl: scan sequencer of the password capability checker
// Walks the password table or the call slots and their entry ranges, and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_kind,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire pcc_pkg::t_status i_status,
    output pcc_pkg::t_cmd         o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_CAP_RD   = 8'b0000_0010,
        ST_CAP_CHK  = 8'b0000_0100,
        ST_SLOT_RD  = 8'b0000_1000,
        ST_SLOT_CHK = 8'b0001_0000,
        ST_EP_RD    = 8'b0010_0000,
        ST_EP_CHK   = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    pcc_pkg::t_res_sel r_res;
    pcc_pkg::t_res_sel n_res;
    logic              r_out_valid;
    logic              n_out_valid;

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        n_res           = r_res;
        o_cmd           = '0;
        o_cmd.res_sel   = r_res;
        o_cmd.accept    = i_in_valid && (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_kind == pcc_pkg::KIND_VALIDATE)) begin
                    o_cmd.item_load = 1'b1;
                    o_cmd.cap_clr   = 1'b1;
                    o_cmd.slot_clr  = 1'b1;
                    n_state = i_status.in_call ? ST_SLOT_RD : ST_CAP_RD;
                end
            end
            ST_CAP_RD: begin
                if (i_status.cap_end) begin
                    n_res   = pcc_pkg::RES_UNKNOWN;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CAP_CHK;
                end
            end
            ST_CAP_CHK: begin
                // The deny test wins over the cover test on the same entry.
                if (i_status.cap_match && i_status.cap_deny) begin
                    n_res   = pcc_pkg::RES_DENIED;
                    n_state = ST_DONE;
                end else if (i_status.cap_match && i_status.cap_allow) begin
                    n_res   = pcc_pkg::RES_CAP_OK;
                    n_state = ST_DONE;
                end else begin
                    o_cmd.cap_inc = 1'b1;
                    n_state = ST_CAP_RD;
                end
            end
            ST_SLOT_RD: begin
                if (i_status.slot_end) begin
                    n_res   = pcc_pkg::RES_UNKNOWN;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SLOT_CHK;
                end
            end
            ST_SLOT_CHK: begin
                if (i_status.slot_match) begin
                    o_cmd.ep_start = 1'b1;
                    n_state = ST_EP_RD;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                    n_state = ST_SLOT_RD;
                end
            end
            ST_EP_RD: begin
                if (i_status.ep_end) begin
                    o_cmd.slot_inc = 1'b1;
                    n_state = ST_SLOT_RD;
                end else begin
                    n_state = ST_EP_CHK;
                end
            end
            ST_EP_CHK: begin
                if (i_status.ep_match) begin
                    n_res   = pcc_pkg::RES_CALL_OK;
                    n_state = ST_DONE;
                end else begin
                    o_cmd.ep_inc = 1'b1;
                    n_state = ST_EP_RD;
                end
            end
            ST_DONE: begin
                // Wait here only while the previous result beat is still unclaimed.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res       <= pcc_pkg::RES_UNKNOWN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/password_capability_checker.sv
// ----------------------------------------------------------------------------
// password_capability_checker: password and protected-call validation
// Loads fill the password table, the call slot table and the entry-point
// list; a validate beat scans them and returns one verdict beat.
// ----------------------------------------------------------------------------
//  Channel   Signals                                  Direction
//  input     i_in_valid / o_in_ready / i_in_item      in
//  output    o_out_valid / i_out_ready / o_out_item   out
//  config    i_cfg_we / i_cfg_idx / i_cfg_data        in, write only
//
//  A load beat fills its table entry and yields no result. A validate beat
//  reads, then checks, each password entry in turn until one decides or
//  the scan runs past the last entry; a call check likewise walks the call
//  slots and each matching slot's entry points, each one read then checked.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A finished result waits in the output register while a new beat is taken;
//  the scan stalls at its end only while that register is full and unclaimed.
// ----------------------------------------------------------------------------
`default_nettype none

module password_capability_checker #(
    parameter int CAP_SLOTS    = 16,
    parameter int CALL_SLOTS   = 8,
    parameter int ENTRY_POINTS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [pcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire pcc_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output pcc_pkg::t_out_item                 o_out_item
);

    pcc_pkg::t_cmd    cmd;
    pcc_pkg::t_status status;

    pcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in_item.kind),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pcc_datapath #(
        .CAP_SLOTS    (CAP_SLOTS),
        .CALL_SLOTS   (CALL_SLOTS),
        .ENTRY_POINTS (ENTRY_POINTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire
